/* src/kptb_pkg.sv */
// Package for the kmer path to bases block: kmer length, field widths and
// the packed payload types of the input and result channels. No dependencies.
`timescale 1ns / 1ps

package kptb_pkg;

  // Bases per kmer, two bits per base.
  localparam int BASES_PER_KMER = 5;
  localparam int KMER_W         = 2 * BASES_PER_KMER;

  localparam int STATE_W = 11;
  localparam int BASES_W = 10;
  localparam int COUNT_W = 3;
  localparam int POS_W   = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef logic [KMER_W-1:0]  kmer_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] kmer_state;
    logic                      new_read;
  } kptb_in_t;

  typedef struct packed {
    logic [BASES_W-1:0] new_bases;
    count_t             new_count;
    pos_t               read_position;
  } kptb_out_t;

endpackage

/* src/kptb_overlap.sv */
// Overlap finder: smallest shift at which the previous kmer's suffix equals
// the new kmer's prefix, or BASES_PER_KMER when none does. Uses kptb_pkg.
`timescale 1ns / 1ps

module kptb_overlap (
  input  kptb_pkg::kmer_t  prev_kmer,
  input  kptb_pkg::kmer_t  cur_kmer,
  output kptb_pkg::count_t shift
);

  always_comb begin
    kptb_pkg::kmer_t diff;
    shift = kptb_pkg::count_t'(kptb_pkg::BASES_PER_KMER);
    // Walk from the largest shift down so that the smallest match wins.
    for (int s = kptb_pkg::BASES_PER_KMER - 1; s >= 1; s--) begin
      diff = (prev_kmer << (2 * s)) ^ cur_kmer;
      if ((diff >> (2 * s)) == '0) begin
        shift = kptb_pkg::count_t'(s);
      end
    end
  end

endmodule

/* src/kmer_path_to_bases.sv */
// Top level of the kmer path to bases block: input register, base emission
// logic with read state, and result register. Uses kptb_pkg and kptb_overlap.
`timescale 1ns / 1ps

// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one decoded kmer
//   state per transaction; a negative kmer_state is a stay, and new_read
//   clears the read state before that transaction is handled. The result
//   channel (out_valid, out_ready, out_data) returns exactly one transaction
//   per input: the bases that the kmer adds, their count and the running
//   base position, which saturates at 65535.
//   An accepted transaction is held in the input register and then moves
//   into the result register, which drives out_valid and out_data. The
//   overlap compares all shifts in parallel, so one transaction is accepted
//   every cycle while the receiver keeps out_ready high.
//   When the receiver holds out_ready low, a full result register holds and
//   the input register takes at most one more transaction before in_ready
//   drops. The read state only advances when an item moves into the result
//   register, so stalls never disturb it.
//   Synchronous reset empties both registers and clears the read state.
module kmer_path_to_bases (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kptb_pkg::kptb_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kptb_pkg::kptb_out_t out_data
);

  logic               in_valid_r;
  kptb_pkg::kptb_in_t in_data_r;
  logic                out_valid_r;
  kptb_pkg::kptb_out_t out_data_r;
  kptb_pkg::kptb_out_t out_data_nxt;

  kptb_pkg::kmer_t  prev_kmer_r, prev_kmer_nxt;
  logic             seen_first_r, seen_first_nxt;
  kptb_pkg::pos_t   pos_r, pos_nxt;

  logic             advance;
  logic             stay;
  kptb_pkg::kmer_t  kmer;
  kptb_pkg::kmer_t  prev_eff;
  logic             seen_eff;
  kptb_pkg::pos_t   pos_eff;
  kptb_pkg::count_t shift;

  // True when base pair i (counted from the tail) is among the emitted bases.
  function automatic logic count_ok(input int i, input kptb_pkg::count_t s);
    return i < int'(s);
  endfunction

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign stay = in_data_r.kmer_state[kptb_pkg::STATE_W-1];
  assign kmer = kptb_pkg::kmer_t'(in_data_r.kmer_state[kptb_pkg::KMER_W-1:0]);

  // A new read starts from the reset state.
  assign prev_eff = in_data_r.new_read ? '0 : prev_kmer_r;
  assign seen_eff = in_data_r.new_read ? 1'b0 : seen_first_r;
  assign pos_eff  = in_data_r.new_read ? '0 : pos_r;

  kptb_overlap u_overlap (
    .prev_kmer (prev_eff),
    .cur_kmer  (kmer),
    .shift     (shift)
  );

  always_comb begin
    logic [kptb_pkg::POS_W:0] sum;
    kptb_pkg::kmer_t          keep;
    sum            = {1'b0, pos_eff} + (kptb_pkg::POS_W + 1)'(shift);
    keep           = '0;
    for (int i = 0; i < kptb_pkg::BASES_PER_KMER; i++) begin
      if (count_ok(i, shift)) begin
        keep[2*i +: 2] = 2'b11;
      end
    end
    prev_kmer_nxt  = prev_eff;
    seen_first_nxt = seen_eff;
    pos_nxt        = pos_eff;
    out_data_nxt.new_bases = '0;
    out_data_nxt.new_count = '0;
    if (!stay) begin
      prev_kmer_nxt = kmer;
      if (!seen_eff) begin
        seen_first_nxt = 1'b1;
        out_data_nxt.new_bases = kptb_pkg::BASES_W'(kmer);
        out_data_nxt.new_count = kptb_pkg::count_t'(kptb_pkg::BASES_PER_KMER);
      end else begin
        out_data_nxt.new_bases = kptb_pkg::BASES_W'(kmer & keep);
        out_data_nxt.new_count = shift;
        pos_nxt = sum[kptb_pkg::POS_W] ? kptb_pkg::POS_MAX : sum[kptb_pkg::POS_W-1:0];
      end
    end
    out_data_nxt.read_position = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_kmer_r  <= '0;
      seen_first_r <= 1'b0;
      pos_r        <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        prev_kmer_r  <= prev_kmer_nxt;
        seen_first_r <= seen_first_nxt;
        pos_r        <= pos_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never exceeds one kmer's worth of bases.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.new_count <= kptb_pkg::count_t'(kptb_pkg::BASES_PER_KMER))
    else $error("new_count above kmer length");

  // Nothing emitted means no base bits set.
  a_empty_bases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_count == '0 |-> out_data.new_bases == '0)
    else $error("bases set with zero count");

  // A stay without a new read leaves the read state alone.
  a_stay_holds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stay && !in_data_r.new_read |=>
      prev_kmer_r == $past(prev_kmer_r) && pos_r == $past(pos_r)
      && seen_first_r == $past(seen_first_r))
    else $error("stay changed read state");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
